// ===== sv/zero_crossing_period_detector_core_defines.svh =====
// Assertion macros shared by the detector RTL.
// Each macro expects clk and rst to exist in the module that uses it.
`ifndef ZERO_CROSSING_PERIOD_DETECTOR_CORE_DEFINES_SVH
`define ZERO_CROSSING_PERIOD_DETECTOR_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ZCPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ZCPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/zcpd_pkg.sv =====
`default_nettype none

package zcpd_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int SAMPLE_DROP  = 4;
  localparam int VALUE_W      = 8;
  localparam int PERIOD_W     = 20;
  localparam int PEAK_W       = 8;
  localparam int SLOPE_TOL_W  = 8;
  localparam int INTV_TOL_W   = 16;
  localparam int WINDOW_W     = 16;
  localparam int MISS_LIMIT_W = 4;
  // One more bit than the limit so the count can pass a limit of fifteen.
  localparam int MISS_W       = MISS_LIMIT_W + 1;
  localparam int APB_ADDR_W   = 4;
  localparam int APB_DATA_W   = 32;

  localparam logic [VALUE_W-1:0]  MIDPOINT   = 8'd127;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  localparam logic [SLOPE_TOL_W-1:0]  RST_SLOPE_TOL  = 8'd3;
  localparam logic [INTV_TOL_W-1:0]   RST_INTV_TOL   = 16'd10;
  localparam logic [WINDOW_W-1:0]     RST_AMP_WINDOW = 16'd1000;
  localparam logic [MISS_LIMIT_W-1:0] RST_MISS_LIMIT = 4'd9;

  typedef enum logic [1:0] {
    REG_SLOPE_TOL  = 2'd0,
    REG_INTV_TOL   = 2'd1,
    REG_AMP_WINDOW = 2'd2,
    REG_MISS_LIMIT = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SLOPE_TOL_W-1:0]  slope_tolerance;
    logic [INTV_TOL_W-1:0]   interval_tolerance;
    logic [WINDOW_W-1:0]     amplitude_window;
    logic [MISS_LIMIT_W-1:0] miss_limit;
  } cfg_t;

  function automatic logic [VALUE_W-1:0] abs_diff8(input logic [VALUE_W-1:0] a,
                                                   input logic [VALUE_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ===== sv/zcpd_ifaces.sv =====
`default_nettype none

interface zcpd_sample_if;
  logic                           valid;
  logic                           ready;
  logic [zcpd_pkg::SAMPLE_W-1:0]  sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

interface zcpd_result_if;
  logic                           valid;
  logic                           ready;
  logic [zcpd_pkg::PERIOD_W-1:0]  period;
  logic                           period_updated;
  logic [zcpd_pkg::PEAK_W-1:0]    peak_amplitude;
  logic                           peak_updated;

  modport source(output valid, output period, output period_updated,
                 output peak_amplitude, output peak_updated, input ready);
  modport sink(input valid, input period, input period_updated,
               input peak_amplitude, input peak_updated, output ready);
endinterface

`default_nettype wire

// ===== sv/zcpd_cfg_regs.sv =====
`default_nettype none

module zcpd_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [zcpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [zcpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [zcpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output zcpd_pkg::cfg_t                       cfg
);

  zcpd_pkg::reg_idx_t reg_idx;
  logic               wr_en;

  // Registers sit on word addresses; the low address bits are ignored.
  assign reg_idx = zcpd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slope_tolerance    <= zcpd_pkg::RST_SLOPE_TOL;
      cfg.interval_tolerance <= zcpd_pkg::RST_INTV_TOL;
      cfg.amplitude_window   <= zcpd_pkg::RST_AMP_WINDOW;
      cfg.miss_limit         <= zcpd_pkg::RST_MISS_LIMIT;
    end else if (wr_en) begin
      unique case (reg_idx)
        zcpd_pkg::REG_SLOPE_TOL: begin
          cfg.slope_tolerance <= pwdata[zcpd_pkg::SLOPE_TOL_W-1:0];
        end
        zcpd_pkg::REG_INTV_TOL: begin
          cfg.interval_tolerance <= pwdata[zcpd_pkg::INTV_TOL_W-1:0];
        end
        zcpd_pkg::REG_AMP_WINDOW: begin
          cfg.amplitude_window <= pwdata[zcpd_pkg::WINDOW_W-1:0];
        end
        zcpd_pkg::REG_MISS_LIMIT: begin
          cfg.miss_limit <= pwdata[zcpd_pkg::MISS_LIMIT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      zcpd_pkg::REG_SLOPE_TOL:  prdata[zcpd_pkg::SLOPE_TOL_W-1:0]  = cfg.slope_tolerance;
      zcpd_pkg::REG_INTV_TOL:   prdata[zcpd_pkg::INTV_TOL_W-1:0]   = cfg.interval_tolerance;
      zcpd_pkg::REG_AMP_WINDOW: prdata[zcpd_pkg::WINDOW_W-1:0]     = cfg.amplitude_window;
      zcpd_pkg::REG_MISS_LIMIT: prdata[zcpd_pkg::MISS_LIMIT_W-1:0] = cfg.miss_limit;
      default:                  prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/zero_crossing_period_detector_core.sv =====
// Zero-crossing period detector. Each request carries one 12-bit converter sample, of which
// bits 11 to 4 are used, and produces exactly one result: the latest period in samples, a
// flag set when this sample completed a period match, the peak deviation from mid-scale of
// the last finished amplitude window, and a flag set when this sample closed a window.
// Rising crossings of mid-scale whose slope matches the steepest slope seen are timed and
// their intervals kept in an on-chip interval memory of STORE_DEPTH entries. Each sample
// passes the evaluate and finish states before the next is accepted; a crossing that must
// be compared with the first stored interval also passes the compare state, and a matched
// period the summation state, which walks the stored intervals one entry per cycle over
// the single read port of the interval memory. A finished result waits in an output
// register, so the next sample is accepted while the previous result is still waiting to
// be taken. The user must write tolerances, window length and the miss limit over the APB
// port only while the block is idle; the block itself does not enforce this.
`default_nettype none
`include "zero_crossing_period_detector_core_defines.svh"

module zero_crossing_period_detector_core #(
  parameter int STORE_DEPTH = 10,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  zcpd_sample_if.sink                          samples,
  zcpd_result_if.source                        results,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [zcpd_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [zcpd_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [zcpd_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  localparam int IDX_W  = $clog2(STORE_DEPTH);
  localparam int ITOL_W = (COUNT_WIDTH > zcpd_pkg::INTV_TOL_W) ? COUNT_WIDTH
                                                                : zcpd_pkg::INTV_TOL_W;
  localparam int ACC_W  = ((COUNT_WIDTH > zcpd_pkg::PERIOD_W) ? COUNT_WIDTH
                                                               : zcpd_pkg::PERIOD_W) + 1;
  localparam logic [COUNT_WIDTH-1:0] ELAPSED_MAX = '1;

  localparam int VW = zcpd_pkg::VALUE_W;

  // One-hot sequencer: evaluate the sample, compare with the first stored
  // interval, sum the stored intervals, then hand the result to the output.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_EVAL   = 5'b00010,
    S_CMP    = 5'b00100,
    S_SUM    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  zcpd_pkg::cfg_t cfg;

  zcpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  state_t state;

  // Detector state.
  logic [VW-1:0]                    last_sample;
  logic [COUNT_WIDTH-1:0]           elapsed;
  logic [VW-1:0]                    first_slope;
  logic [IDX_W-1:0]                 store_index;
  logic [VW-1:0]                    steepest_slope;
  logic [zcpd_pkg::MISS_W-1:0]      miss_count;
  logic [zcpd_pkg::PERIOD_W-1:0]    period_reg;
  logic [zcpd_pkg::WINDOW_W-1:0]    window_count;
  logic [VW-1:0]                    running_peak;
  logic [VW-1:0]                    last_peak;

  // Per-sample working registers.
  logic [VW-1:0]                    sample_r;
  logic [VW-1:0]                    slope_r;
  logic [COUNT_WIDTH-1:0]           interval_r;
  logic [IDX_W-1:0]                 idx_r;
  logic [IDX_W-1:0]                 rd_ptr;
  logic [zcpd_pkg::PERIOD_W-1:0]    acc;
  logic                             p_upd_r;
  logic                             a_upd_r;

  // Output register.
  logic                             out_valid;
  logic [zcpd_pkg::PERIOD_W-1:0]    out_period;
  logic                             out_p_upd;
  logic [zcpd_pkg::PEAK_W-1:0]      out_peak;
  logic                             out_a_upd;

  // Interval memory: one write port, one registered read port.
  logic [COUNT_WIDTH-1:0]           interval_store [STORE_DEPTH];
  logic                             mem_we;
  logic [IDX_W-1:0]                 mem_waddr;
  logic [COUNT_WIDTH-1:0]           mem_wdata;
  logic [IDX_W-1:0]                 mem_raddr;
  logic [COUNT_WIDTH-1:0]           mem_rdata;

  // Combinational decision terms.
  logic                             crossing;
  logic [VW-1:0]                    slope;
  logic                             slope_match;
  logic [IDX_W-1:0]                 idx;
  logic [COUNT_WIDTH-1:0]           elapsed_inc;
  logic [zcpd_pkg::MISS_W-1:0]      miss_inc;
  logic [VW-1:0]                    dev;
  logic [VW-1:0]                    peak_now;
  logic [zcpd_pkg::WINDOW_W-1:0]    wc_inc;
  logic [COUNT_WIDTH-1:0]           intv_diff;
  logic                             period_match;
  logic [IDX_W:0]                   idx_inc;
  logic [IDX_W:0]                   rd_ptr_inc;
  logic                             sum_last;
  logic [ACC_W-1:0]                 sum_full;
  logic [zcpd_pkg::PERIOD_W-1:0]    sum_sat;
  logic                             out_free;

  assign samples.ready = (state == S_IDLE);

  assign results.valid          = out_valid;
  assign results.period         = out_period;
  assign results.period_updated = out_p_upd;
  assign results.peak_amplitude = out_peak;
  assign results.peak_updated   = out_a_upd;

  assign out_free = !out_valid || results.ready;

  always_comb begin
    // A rising crossing: previous value below mid-scale, new value at or above it.
    crossing    = (last_sample < zcpd_pkg::MIDPOINT) && (sample_r >= zcpd_pkg::MIDPOINT);
    slope       = sample_r - last_sample;
    slope_match = zcpd_pkg::abs_diff8(slope, steepest_slope) < cfg.slope_tolerance;
    idx         = ({1'b0, store_index} >= (IDX_W + 1)'(STORE_DEPTH)) ? '0 : store_index;
    elapsed_inc = (elapsed == ELAPSED_MAX) ? elapsed : (elapsed + COUNT_WIDTH'(1));
    miss_inc    = miss_count + zcpd_pkg::MISS_W'(1);

    dev      = (sample_r >= zcpd_pkg::MIDPOINT) ? (sample_r - zcpd_pkg::MIDPOINT)
                                                 : (zcpd_pkg::MIDPOINT - sample_r);
    peak_now = (dev > running_peak) ? dev : running_peak;
    wc_inc   = window_count + zcpd_pkg::WINDOW_W'(1);

    // The first stored interval arrives on the read port while in the compare state.
    intv_diff    = (mem_rdata > interval_r) ? (mem_rdata - interval_r)
                                            : (interval_r - mem_rdata);
    period_match = (ITOL_W'(intv_diff) < ITOL_W'(cfg.interval_tolerance))
                && (zcpd_pkg::abs_diff8(first_slope, slope_r) < cfg.slope_tolerance);
    idx_inc      = {1'b0, idx_r} + (IDX_W + 1)'(1);

    // Saturating accumulation; the partial sums only grow, so clipping each
    // step gives the same result as clipping the total.
    rd_ptr_inc = {1'b0, rd_ptr} + (IDX_W + 1)'(1);
    sum_last   = (rd_ptr_inc == {1'b0, idx_r});
    sum_full   = ACC_W'(acc) + ACC_W'(mem_rdata);
    sum_sat    = (sum_full > ACC_W'(zcpd_pkg::PERIOD_MAX)) ? zcpd_pkg::PERIOD_MAX
                                                             : sum_full[zcpd_pkg::PERIOD_W-1:0];
  end

  // Memory port control. The write of the new interval and the read of the
  // first entry in the evaluate state can hit the same entry only for a zero
  // index, and then the compare path is not taken, so that read goes unused;
  // the first entry's final write follows its read, so no forwarding is needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wdata = elapsed;
    mem_raddr = '0;
    unique case (state)
      S_EVAL: begin
        mem_we    = crossing && slope_match;
        mem_waddr = idx;
        mem_wdata = elapsed;
        mem_raddr = '0;
      end
      S_CMP: begin
        mem_raddr = '0;
      end
      S_SUM: begin
        mem_raddr = rd_ptr_inc[IDX_W-1:0];
        if (sum_last) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = interval_r;
        end
      end
      S_IDLE, S_FINISH: begin
        mem_raddr = '0;
      end
      default: begin
        mem_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      interval_store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= interval_store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      last_sample    <= '0;
      elapsed        <= '0;
      first_slope    <= '0;
      store_index    <= '0;
      steepest_slope <= '0;
      miss_count     <= '0;
      period_reg     <= '0;
      window_count   <= '0;
      running_peak   <= '0;
      last_peak      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            sample_r <= samples.sample[zcpd_pkg::SAMPLE_W-1:zcpd_pkg::SAMPLE_DROP];
            state    <= S_EVAL;
          end
        end

        S_EVAL: begin
          last_sample <= sample_r;
          p_upd_r     <= 1'b0;
          elapsed     <= elapsed_inc;
          state       <= S_FINISH;

          // Amplitude window runs on every sample.
          if (wc_inc == cfg.amplitude_window) begin
            window_count <= '0;
            last_peak    <= peak_now;
            running_peak <= '0;
            a_upd_r      <= 1'b1;
          end else begin
            window_count <= wc_inc;
            running_peak <= peak_now;
            a_upd_r      <= 1'b0;
          end

          if (crossing) begin
            priority if (slope_match) begin
              // Interval is written to the store by the memory port this cycle.
              elapsed    <= COUNT_WIDTH'(1);
              slope_r    <= slope;
              interval_r <= elapsed;
              idx_r      <= idx;
              if (idx == '0) begin
                first_slope <= slope;
                miss_count  <= '0;
                store_index <= IDX_W'(1);
              end else begin
                state <= S_CMP;
              end
            end else if (slope > steepest_slope) begin
              // A steeper crossing restarts the interval collection.
              steepest_slope <= slope;
              elapsed        <= COUNT_WIDTH'(1);
              miss_count     <= '0;
              store_index    <= '0;
            end else begin
              if (miss_inc > zcpd_pkg::MISS_W'(cfg.miss_limit)) begin
                store_index    <= '0;
                miss_count     <= '0;
                steepest_slope <= '0;
              end else begin
                miss_count <= miss_inc;
              end
            end
          end
        end

        S_CMP: begin
          if (period_match) begin
            acc    <= '0;
            rd_ptr <= '0;
            state  <= S_SUM;
          end else begin
            state <= S_FINISH;
            // Store full: drop everything collected and start over.
            if (idx_inc > (IDX_W + 1)'(STORE_DEPTH - 1)) begin
              store_index    <= '0;
              miss_count     <= '0;
              steepest_slope <= '0;
            end else begin
              store_index <= idx_inc[IDX_W-1:0];
            end
          end
        end

        S_SUM: begin
          acc    <= sum_sat;
          rd_ptr <= rd_ptr_inc[IDX_W-1:0];
          if (sum_last) begin
            // The matched interval becomes the new first entry.
            period_reg  <= sum_sat;
            p_upd_r     <= 1'b1;
            first_slope <= slope_r;
            store_index <= IDX_W'(1);
            miss_count  <= '0;
            state       <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_period <= period_reg;
            out_p_upd  <= p_upd_r;
            out_peak   <= last_peak;
            out_a_upd  <= a_upd_r;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The index always names an entry that exists.
  `ZCPD_ASSERT_SAME(a_index_in_range, 1'b1, store_index <= IDX_W'(STORE_DEPTH - 1), "store index past the interval store")
  // An accepted sample is evaluated in the following cycle.
  `ZCPD_ASSERT_NEXT(a_accept_to_eval, samples.valid && samples.ready, state == S_EVAL, "accepted sample not evaluated")
  // A completed match leaves exactly the matched interval in the store.
  `ZCPD_ASSERT_SAME(a_match_restart, (state == S_FINISH) && p_upd_r, (store_index == IDX_W'(1)) && (miss_count == '0), "match did not restart the store")
  // The summation never adds the entry just written or any beyond it.
  `ZCPD_ASSERT_SAME(a_sum_bound, state == S_SUM, rd_ptr < idx_r, "summation ran past the stored intervals")
  // A deviation from mid-scale cannot exceed 128.
  `ZCPD_ASSERT_SAME(a_peak_range, 1'b1, last_peak <= 8'd128, "peak amplitude out of range")

endmodule

`default_nettype wire
